// ===== hw/rtl/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque package
// Command and status codes, the per-cycle cell operation and the control
// state encoding shared by the cell row and the top level.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned STATUS_W = 2;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK = 2'd0,
		CMD_POP_FRONT = 2'd1,
		CMD_POP_BACK  = 2'd2,
		CMD_LIST      = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation broadcast to every cell of the row in the same cycle.
	typedef struct packed {
		logic push;
		logic pop_front;
		logic pop_back;
		logic rotate;
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} ctrl_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/deq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface deq_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               cmd;
	logic signed [31:0]       value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

interface deq_rsp_if;
	logic                     valid;
	logic                     ready;
	logic signed [31:0]       item_value;
	logic [1:0]               status;
	logic                     is_last;

	modport source (output valid, output item_value, output status, output is_last,
		input ready);
	modport sink (input valid, input item_value, input status, input is_last,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/deq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque cell
// One slot of the row. Cell 0 holds the front; occupied cells form a
// contiguous run from cell 0. Each cycle a cell may load its right
// neighbor (pop front, rotate), the pushed value or the front value.
// ----------------------------------------------------------------------------
module deq_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire deq_pkg::cell_op_t op,
	input  wire deq_pkg::value_t   push_value,
	input  wire deq_pkg::value_t   front_value,
	input  wire logic              left_occ,
	input  wire logic              right_occ,
	input  wire deq_pkg::value_t   right_value,
	output deq_pkg::value_t        value,
	output logic                   occ
);
	import deq_pkg::*;

	value_t value_q;
	logic   occ_q;
	logic   is_tail_free;
	logic   is_back;

	// The first free cell takes a push; the last held cell is the back.
	assign is_tail_free = left_occ && !occ_q;
	assign is_back = occ_q && !right_occ;

	// Occupancy bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (op.push && is_tail_free) begin
			occ_q <= 1'b1;
		end else if (op.pop_front) begin
			occ_q <= right_occ;
		end else if (op.pop_back && is_back) begin
			occ_q <= 1'b0;
		end
	end

	// Payload: load a push, shift toward the front, wrap the front into the back on rotate.
	always_ff @(posedge clk) begin
		if (op.push && is_tail_free) begin
			value_q <= push_value;
		end else if (op.pop_front || (op.rotate && right_occ)) begin
			value_q <= right_value;
		end else if (op.rotate && is_back) begin
			value_q <= front_value;
		end
	end

	assign value = value_q;
	assign occ = occ_q;

endmodule
`default_nettype wire

// ===== hw/rtl/deque_push_pop_list_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque push/pop/list core
// Bounded double-ended queue of signed 32-bit values in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries command beats (cmd, value); rsp carries result beats
//   (item_value, status, is_last). Push back, pop front and pop back each
//   give one result beat, registered, in the cycle after the command beat; a
//   new command can be taken in the next cycle, so while rsp.ready is high
//   these run at one per cycle. List gives one beat per held entry, front
//   to back, one per cycle while rsp.ready is high, with is_last on the
//   final one; while it runs, req.ready is low. Listing rotates the cell
//   row once per beat, so the row is back in its original order when the
//   last beat is issued. A list of an empty queue gives one beat with the
//   empty status. When rsp.ready is low the result register holds its beat
//   and the core neither takes commands nor advances a list until the beat
//   is taken. Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module deque_push_pop_list_core #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	value_t            cell_value [DEPTH];
	logic [DEPTH-1:0]  cell_occ;
	cell_op_t          op;

	ctrl_state_t       state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;

	logic              out_valid_q;
	value_t            item_value_q;
	status_t           status_q;
	logic              is_last_q;

	logic              out_free;
	logic              accept;
	logic              emit;
	value_t            emit_value;
	status_t           emit_status;
	logic              emit_last;
	logic              is_full;
	logic              is_empty;
	logic              list_start;
	cmd_t              cmd;

	assign is_full = cell_occ[DEPTH-1];
	assign is_empty = !cell_occ[0];
	assign cmd = cmd_t'(req.cmd);

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept = req.valid && req.ready;

	// Command decode and result selection.
	always_comb begin
		op = '0;
		emit = 1'b0;
		emit_value = '0;
		emit_status = ST_OK;
		emit_last = 1'b1;
		list_start = 1'b0;
		if (state_q == S_LIST) begin
			if (out_free) begin
				emit = 1'b1;
				emit_value = cell_value[0];
				emit_last = (idx_q == (count_q - CNT_W'(1)));
				op.rotate = 1'b1;
			end
		end else if (accept) begin
			emit = 1'b1;
			unique case (cmd)
				CMD_PUSH_BACK: begin
					if (is_full) emit_status = ST_FULL;
					else op.push = 1'b1;
				end
				CMD_POP_FRONT: begin
					if (is_empty) emit_status = ST_EMPTY;
					else op.pop_front = 1'b1;
				end
				CMD_POP_BACK: begin
					if (is_empty) emit_status = ST_EMPTY;
					else op.pop_back = 1'b1;
				end
				CMD_LIST: begin
					if (is_empty) begin
						emit_status = ST_EMPTY;
					end else begin
						emit_value = cell_value[0];
						emit_last = (count_q == CNT_W'(1));
						op.rotate = 1'b1;
						list_start = (count_q != CNT_W'(1));
					end
				end
				default: ;
			endcase
		end
	end

	// Control state, fill count and list position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
		end else begin
			if (op.push) count_q <= count_q + CNT_W'(1);
			else if (op.pop_front || op.pop_back) count_q <= count_q - CNT_W'(1);
			unique case (state_q)
				S_IDLE: begin
					if (list_start) begin
						state_q <= S_LIST;
						idx_q <= CNT_W'(1);
					end
				end
				S_LIST: begin
					if (emit) begin
						idx_q <= idx_q + CNT_W'(1);
						if (emit_last) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			item_value_q <= emit_value;
			status_q <= emit_status;
			is_last_q <= emit_last;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.item_value = item_value_q;
	assign rsp.status = status_q;
	assign rsp.is_last = is_last_q;

	// Row of cells; cell 0 is the front of the queue.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   left_occ;
		logic   right_occ;
		value_t right_value;

		if (i == 0) begin : g_first
			assign left_occ = 1'b1;
		end else begin : g_mid
			assign left_occ = cell_occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_occ = 1'b0;
			assign right_value = '0;
		end else begin : g_inner
			assign right_occ = cell_occ[i+1];
			assign right_value = cell_value[i+1];
		end

		deq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.push_value  (req.value),
			.front_value (cell_value[0]),
			.left_occ    (left_occ),
			.right_occ   (right_occ),
			.right_value (right_value),
			.value       (cell_value[i]),
			.occ         (cell_occ[i])
		);
	end

endmodule
`default_nettype wire

// ===== tb/deque_push_pop_list_core_tb.sv =====
// ----------------------------------------------------------------------------
// Deque push/pop/list core testbench
// Drives command beats from a queue of pending commands and checks every
// result beat against a behavioral deque kept inside the bench. Both
// channels stall at random, apart from a stretch of cycles that runs at
// full rate.
// ----------------------------------------------------------------------------
module deque_push_pop_list_core_tb;

	import deq_pkg::*;

	localparam int DEQ_DEPTH = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int CMD_TOTAL = 180;
	localparam int IDLE_PERCENT = 32;
	localparam int QUIET_START = 300;
	localparam int QUIET_END = 800;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRINT_CAP = 50;

	typedef struct {
		cmd_t   cmd;
		value_t value;
	} cmd_beat_t;

	typedef struct {
		value_t  item_value;
		status_t status;
		logic    is_last;
	} result_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Bench-side copies of the channel signals, known from time zero.
	logic       cmd_valid = 1'b0;
	logic [1:0] cmd_code = '0;
	value_t     cmd_value = '0;
	logic       result_ready = 1'b0;

	int cycle_cnt = 0;
	int error_count = 0;

	cmd_beat_t    pending_cmds[$];
	result_beat_t expected_results[$];

	// Behavioral deque: ring store, front and back slots, and the fill count.
	value_t deque_store [DEQ_DEPTH];
	int     front_slot = 0;
	int     back_slot = 0;
	int     held_count = 0;

	deq_req_if req_if ();
	deq_rsp_if rsp_if ();

	assign req_if.valid = cmd_valid;
	assign req_if.cmd = cmd_code;
	assign req_if.value = cmd_value;
	assign rsp_if.ready = result_ready;

	deque_push_pop_list_core #(
		.DEPTH(DEQ_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #10 clk = ~clk;

	// Cycle count and the overall time limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic bit idle_now();
		if (cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PERCENT;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
	endtask

	task automatic add_cmd(input cmd_t c, input value_t v);
		cmd_beat_t b;
		b.cmd = c;
		b.value = v;
		pending_cmds.push_back(b);
	endtask

	task automatic expect_result(input value_t v, input status_t s, input logic last);
		result_beat_t r;
		r.item_value = v;
		r.status = s;
		r.is_last = last;
		expected_results.push_back(r);
	endtask

	// Applies one accepted command to the behavioral deque and queues the
	// result beats it must produce.
	task automatic deque_apply(input cmd_t c, input value_t v);
		int k;
		case (c)
			CMD_PUSH_BACK: begin
				if (held_count == DEQ_DEPTH) begin
					expect_result('0, ST_FULL, 1'b1);
				end else begin
					deque_store[back_slot] = v;
					back_slot = (back_slot + 1) % DEQ_DEPTH;
					held_count++;
					expect_result('0, ST_OK, 1'b1);
				end
			end
			CMD_POP_FRONT: begin
				if (held_count == 0) begin
					expect_result('0, ST_EMPTY, 1'b1);
				end else begin
					front_slot = (front_slot + 1) % DEQ_DEPTH;
					held_count--;
					expect_result('0, ST_OK, 1'b1);
				end
			end
			CMD_POP_BACK: begin
				if (held_count == 0) begin
					expect_result('0, ST_EMPTY, 1'b1);
				end else begin
					back_slot = (back_slot + DEQ_DEPTH - 1) % DEQ_DEPTH;
					held_count--;
					expect_result('0, ST_OK, 1'b1);
				end
			end
			default: begin
				if (held_count == 0) begin
					expect_result('0, ST_EMPTY, 1'b1);
				end else begin
					for (k = 0; k < held_count; k++)
						expect_result(deque_store[(front_slot + k) % DEQ_DEPTH], ST_OK,
							(k + 1 == held_count));
				end
			end
		endcase
	endtask

	// Command driver: a beat stays up until taken; a new one may follow in
	// the very next cycle unless the sender chooses to idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_code <= '0;
			cmd_value <= '0;
		end else begin
			if (cmd_valid && req_if.ready) begin
				deque_apply(cmd_t'(cmd_code), cmd_value);
				void'(pending_cmds.pop_front());
			end
			if (!cmd_valid || req_if.ready) begin
				if (pending_cmds.size() != 0 && !idle_now()) begin
					cmd_valid <= 1'b1;
					cmd_code <= pending_cmds[0].cmd;
					cmd_value <= pending_cmds[0].value;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each taken beat with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_beat_t exp_beat;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (rsp_if.valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					exp_beat = expected_results.pop_front();
					if (rsp_if.item_value !== exp_beat.item_value)
						report_mismatch($sformatf("item_value %0d, expected %0d",
							rsp_if.item_value, exp_beat.item_value));
					if (rsp_if.status !== exp_beat.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp_if.status, exp_beat.status));
					if (rsp_if.is_last !== exp_beat.is_last)
						report_mismatch($sformatf("is_last %0b, expected %0b",
							rsp_if.is_last, exp_beat.is_last));
				end
			end
			result_ready <= !idle_now();
		end
	end

	initial begin
		int n;
		int pick;

		// Directed: empty cases, value extremes, both pops, last-entry pop.
		add_cmd(CMD_LIST, '0);
		add_cmd(CMD_POP_FRONT, '0);
		add_cmd(CMD_POP_BACK, '1);
		add_cmd(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
		add_cmd(CMD_PUSH_BACK, 32'sh8000_0000);
		add_cmd(CMD_PUSH_BACK, -32'sd1);
		add_cmd(CMD_PUSH_BACK, '0);
		add_cmd(CMD_LIST, 32'sh5A5A_A5A5);
		add_cmd(CMD_POP_BACK, '0);
		add_cmd(CMD_POP_FRONT, '0);
		add_cmd(CMD_LIST, '0);
		add_cmd(CMD_POP_BACK, '0);
		add_cmd(CMD_POP_FRONT, '0);
		add_cmd(CMD_LIST, '0);
		add_cmd(CMD_POP_BACK, '0);

		// Random: fill bursts that can reach full, drains, ring wrap and a mix.
		while (pending_cmds.size() < CMD_TOTAL) begin
			case ($urandom_range(0, 3))
				0: begin
					n = $urandom_range(8, 18);
					repeat (n) add_cmd(CMD_PUSH_BACK, value_t'($urandom));
					add_cmd(CMD_LIST, value_t'($urandom));
				end
				1: begin
					n = $urandom_range(4, 18);
					repeat (n)
						add_cmd(cmd_t'($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK),
							value_t'($urandom));
					add_cmd(CMD_LIST, value_t'($urandom));
				end
				2: begin
					n = $urandom_range(3, 10);
					repeat (n) begin
						add_cmd(CMD_PUSH_BACK, value_t'($urandom));
						add_cmd(CMD_POP_FRONT, value_t'($urandom));
					end
					add_cmd(CMD_LIST, value_t'($urandom));
				end
				default: begin
					n = $urandom_range(5, 15);
					repeat (n) begin
						pick = $urandom_range(0, 9);
						if (pick < 4)
							add_cmd(CMD_PUSH_BACK, value_t'($urandom));
						else if (pick < 6)
							add_cmd(CMD_POP_FRONT, value_t'($urandom));
						else if (pick < 8)
							add_cmd(CMD_POP_BACK, value_t'($urandom));
						else
							add_cmd(CMD_LIST, value_t'($urandom));
					end
				end
			endcase
		end

		// Reset once, released away from the rising edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every command to be taken and every result to arrive.
		while (pending_cmds.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
